[hw/rtl/partition_fit_allocator_top_macros.svh]
// assertion helpers for the partition fit allocator
`ifndef PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define PFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define PFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/pfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_PORT_W = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int BLK_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    localparam logic [BLK_W-1:0] BLOCKS_RESET = 5'd16;

    typedef struct packed {
        logic fits;
        logic take;
    } fit_res_t;

endpackage

`default_nettype wire

[hw/rtl/pfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/pfa_fit_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfa_fit_unit #(
    parameter int SIZE_BITS = 16
) (
    input  wire logic [SIZE_BITS-1:0]      have,
    input  wire logic [SIZE_BITS-1:0]      req,
    input  wire logic [SIZE_BITS-1:0]      best,
    input  wire logic                      found,
    input  wire logic [pfa_pkg::MODE_W-1:0] mode,
    output logic      [SIZE_BITS-1:0]      left,
    output pfa_pkg::fit_res_t              res
);

    import pfa_pkg::*;

    logic better;

    always_comb
    begin
        left = have - req;
        case (mode)
            MODE_BEST:  better = left < best;
            MODE_WORST: better = left > best;
            default:    better = 1'b0;
        endcase
        res.fits = have >= req;
        res.take = res.fits && (!found || better);
    end

endmodule

`default_nettype wire

[hw/rtl/partition_fit_allocator_top.sv]
// Placement allocator over a table of free partition sizes. A load item (tuser 0) writes one
// entry. An allocate item (tuser 1) walks the first n entries, where n is blocks_in_use
// capped at TABLE_DEPTH, reading one entry per cycle from the table RAM into a single
// subtract-and-compare unit, then writes the reduced entry back. First fit, best fit and
// worst fit all scan the full range, so the number of entries read does not depend on the
// policy. A compact item (tuser 2) streams the same n entries through the read port, writes
// the nonzero ones to the front through the write port, then zero-fills the rest of the
// range one entry per cycle. The table resets to all zero with no clearing pass. One result
// item leaves per input item through an output register, so the next item can enter while
// the previous result waits; configuration writes belong between items.
`timescale 1ns / 1ps
`default_nettype none
`include "partition_fit_allocator_top_macros.svh"

module partition_fit_allocator_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int SIZE_BITS   = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, amount, zero pad
    input  wire logic [pfa_pkg::S_DATA_W-1:0]   s_tdata,
    // op
    input  wire logic [pfa_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // chosen_index, size_before, size_after, zero pad
    output logic      [pfa_pkg::M_DATA_W-1:0]   m_tdata,
    // status
    output logic      [pfa_pkg::STATUS_W-1:0]   m_tuser
);

    import pfa_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LW    = (CNT_W > BLK_W) ? CNT_W : BLK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_FILL,
        S_RESULT
    } state_t;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       fit_mode_reg;
    logic [BLK_W-1:0]        blocks_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic                    rd_valid_reg;
    logic [SIZE_BITS-1:0]    amount_reg, amount_next;
    logic [LW-1:0]           n_reg, n_next;
    logic [LW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                    found_reg, found_next;
    logic [SIZE_BITS-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]    best_have_reg, best_have_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [IDX_PORT_W-1:0]   res_idx_reg, res_idx_next;
    logic [AMOUNT_W-1:0]     res_before_reg, res_before_next;
    logic [AMOUNT_W-1:0]     res_after_reg, res_after_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]     m_tuser_reg, m_tuser_next;

    logic                    s_accept;
    logic [IDX_PORT_W-1:0]   in_index;
    logic [AMOUNT_W-1:0]     in_amount;
    logic [LW-1:0]           ent_ext;
    logic                    load_ok;
    logic [LW-1:0]           blocks_ext;
    logic [LW-1:0]           n_live;
    logic                    issue;
    logic                    scan_done;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0]    ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [SIZE_BITS-1:0]    ram_rdata;
    logic [SIZE_BITS-1:0]    have;
    logic [SIZE_BITS-1:0]    left;
    fit_res_t                fit;
    logic [LW-1:0]           best_idx_ext;

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .have  (have),
        .req   (amount_reg),
        .best  (best_reg),
        .found (found_reg),
        .mode  (fit_mode_reg),
        .left  (left),
        .res   (fit)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_index  = s_tdata[IDX_PORT_W-1:0];
    assign in_amount = s_tdata[IDX_PORT_W+AMOUNT_W-1:IDX_PORT_W];

    assign ent_ext    = LW'(in_index);
    assign load_ok    = ent_ext < LW'(TABLE_DEPTH);
    assign blocks_ext = LW'(blocks_reg);
    assign n_live     = (blocks_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : blocks_ext;

    assign issue      = ((state_reg == S_SCAN) || (state_reg == S_COMPACT))
                        && (rd_ptr_reg < n_reg);
    assign scan_done  = (rd_ptr_reg >= n_reg) && !pend_reg;
    assign ram_raddr  = rd_ptr_reg[IDX_W-1:0];
    assign have       = rd_valid_reg ? ram_rdata : '0;
    assign best_idx_ext = LW'(best_idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        amount_next     = amount_reg;
        n_next          = n_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pend_next       = issue;
        pend_idx_next   = rd_ptr_reg[IDX_W-1:0];
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_have_next  = best_have_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_before_next = res_before_reg;
        res_after_next  = res_after_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[IDX_W-1:0];
        ram_wdata       = '0;

        if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + LW'(1);
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    amount_next     = SIZE_BITS'(in_amount);
                    n_next          = n_live;
                    rd_ptr_next     = '0;
                    wr_ptr_next     = '0;
                    found_next      = 1'b0;
                    best_next       = '0;
                    best_idx_next   = '0;
                    best_have_next  = '0;
                    res_status_next = STAT_DONE;
                    res_idx_next    = '0;
                    res_before_next = '0;
                    res_after_next  = '0;
                    case (s_tuser)
                        OP_LOAD:
                        begin
                            ram_we     = load_ok;
                            ram_waddr  = ent_ext[IDX_W-1:0];
                            ram_wdata  = SIZE_BITS'(in_amount);
                            state_next = S_RESULT;
                        end
                        OP_ALLOC:   state_next = S_SCAN;
                        OP_COMPACT: state_next = S_COMPACT;
                        default:    state_next = S_RESULT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pend_reg && fit.take)
                begin
                    found_next     = 1'b1;
                    best_next      = left;
                    best_idx_next  = pend_idx_reg;
                    best_have_next = have;
                end
                if (scan_done)
                begin
                    if (found_reg)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = best_idx_reg;
                        ram_wdata       = best_reg;
                        res_status_next = STAT_ALLOCATED;
                        res_idx_next    = best_idx_ext[IDX_PORT_W-1:0];
                        res_before_next = AMOUNT_W'(best_have_reg);
                        res_after_next  = AMOUNT_W'(best_reg);
                    end
                    else
                    begin
                        res_status_next = STAT_NO_FIT;
                    end
                    state_next = S_RESULT;
                end
            end
            S_COMPACT:
            begin
                if (pend_reg && (have != '0))
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = have;
                    wr_ptr_next = wr_ptr_reg + LW'(1);
                end
                if (scan_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (wr_ptr_reg < n_reg)
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + LW'(1);
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = M_DATA_W'({res_after_reg, res_before_reg, res_idx_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fit_mode_reg   <= MODE_FIRST;
            blocks_reg     <= BLOCKS_RESET;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            amount_reg     <= '0;
            n_reg          <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
            best_have_reg  <= '0;
            res_status_reg <= STAT_DONE;
            res_idx_reg    <= '0;
            res_before_reg <= '0;
            res_after_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= STAT_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            amount_reg     <= amount_next;
            n_reg          <= n_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
            best_idx_reg   <= best_idx_next;
            best_have_reg  <= best_have_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_before_reg <= res_before_next;
            res_after_reg  <= res_after_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
            if (issue)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_MODE:      fit_mode_reg <= cfg_data[MODE_W-1:0];
                    CFG_BLOCKS_IN_USE: blocks_reg   <= cfg_data[BLK_W-1:0];
                    default:           fit_mode_reg <= fit_mode_reg;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PFA_ASSERT_NEXT(a_alloc_starts_scan, clk, rst_n, s_tvalid && s_tready && (s_tuser == OP_ALLOC), state_reg == S_SCAN, "allocate item did not start a scan")
    `PFA_ASSERT_NOW(a_compact_order, clk, rst_n, state_reg == S_COMPACT, wr_ptr_reg <= rd_ptr_reg, "compaction write pointer passed read pointer")
    `PFA_ASSERT_NOW(a_ptr_range, clk, rst_n, (state_reg == S_SCAN) || (state_reg == S_COMPACT), rd_ptr_reg <= n_reg, "scan pointer beyond live range")
    `PFA_ASSERT_NOW(a_no_fit_zero, clk, rst_n, m_tvalid && (m_tuser == STAT_NO_FIT), m_tdata == '0, "failed allocation carries nonzero fields")

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int                TABLE_DEPTH  = 16;
    localparam int                RANDOM_ITEMS = 650;
    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                SETTLE_CYCLES = 40;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [IDX_PORT_W-1:0] chosen_index;
        logic [AMOUNT_W-1:0]   size_before;
        logic [AMOUNT_W-1:0]   size_after;
    } alloc_reply_t;

    class alloc_scoreboard;
        logic [AMOUNT_W-1:0] partition_sizes [TABLE_DEPTH];
        logic [MODE_W-1:0]   fit_mode;
        logic [BLK_W-1:0]    blocks_in_use;
        alloc_reply_t        expected_replies [$];
        int                  errors;
        int                  loads, allocs, no_fits, compactions, others, reg_writes;

        function new();
            foreach (partition_sizes[i])
                partition_sizes[i] = '0;
            fit_mode      = MODE_FIRST;
            blocks_in_use = BLOCKS_RESET;
        endfunction

        function int live_entries();
            return (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            if (index == CFG_FIT_MODE)
                fit_mode = value[MODE_W-1:0];
            else
                blocks_in_use = value[BLK_W-1:0];
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [IDX_PORT_W-1:0] entry,
                                   logic [AMOUNT_W-1:0] amount);
            alloc_reply_t        reply;
            int                  n;
            int                  j;
            int                  wr;
            int                  pick;
            bit                  found;
            logic [AMOUNT_W-1:0] leftover;
            logic [AMOUNT_W-1:0] best;
            reply = '0;
            n     = live_entries();
            found = 1'b0;
            pick  = 0;
            best  = '0;
            case (op)
                OP_LOAD:
                begin
                    loads++;
                    partition_sizes[entry] = amount;
                end
                OP_ALLOC:
                begin
                    allocs++;
                    for (j = 0; j < n; j++)
                    begin
                        if (partition_sizes[j] >= amount)
                        begin
                            leftover = partition_sizes[j] - amount;
                            if (fit_mode == MODE_BEST)
                            begin
                                if (!found || leftover < best)
                                begin
                                    found = 1'b1;
                                    best  = leftover;
                                    pick  = j;
                                end
                            end
                            else if (fit_mode == MODE_WORST)
                            begin
                                if (!found || leftover > best)
                                begin
                                    found = 1'b1;
                                    best  = leftover;
                                    pick  = j;
                                end
                            end
                            else if (!found)
                            begin
                                found = 1'b1;
                                pick  = j;
                            end
                        end
                    end
                    if (found)
                    begin
                        reply.status          = STAT_ALLOCATED;
                        reply.chosen_index    = pick[IDX_PORT_W-1:0];
                        reply.size_before     = partition_sizes[pick];
                        partition_sizes[pick] = partition_sizes[pick] - amount;
                        reply.size_after      = partition_sizes[pick];
                    end
                    else
                    begin
                        no_fits++;
                        reply.status = STAT_NO_FIT;
                    end
                end
                OP_COMPACT:
                begin
                    compactions++;
                    wr = 0;
                    for (j = 0; j < n; j++)
                    begin
                        if (partition_sizes[j] != '0)
                        begin
                            partition_sizes[wr] = partition_sizes[j];
                            wr++;
                        end
                    end
                    for (j = wr; j < n; j++)
                        partition_sizes[j] = '0;
                end
                default:
                    others++;
            endcase
            reply.status = (op == OP_ALLOC) ? reply.status : STAT_DONE;
            expected_replies = {expected_replies, reply};
        endfunction

        function void check_reply(alloc_reply_t got);
            alloc_reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("result item with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.chosen_index !== want.chosen_index)
            begin
                $error("chosen_index: expected %0d, actual %0d",
                       want.chosen_index, got.chosen_index);
                errors++;
            end
            if (got.size_before !== want.size_before)
            begin
                $error("size_before: expected %0d, actual %0d",
                       want.size_before, got.size_before);
                errors++;
            end
            if (got.size_after !== want.size_after)
            begin
                $error("size_after: expected %0d, actual %0d",
                       want.size_after, got.size_after);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    alloc_scoreboard sb;
    int              send_idle_pct = 33;
    int              recv_idle_pct = 62;
    int              cycles;

    always #10 clk = ~clk;

    partition_fit_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply({m_tuser, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20]});
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // leaves tvalid high so a following item can go out back to back
    task automatic send_item(logic [OP_W-1:0] op, logic [IDX_PORT_W-1:0] entry,
                             logic [AMOUNT_W-1:0] amount);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, amount, entry};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, entry, amount);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_load_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return '0;
        else if (roll < 20)
            return '1;
        else if (roll < 35)
            return ($urandom_range(1)) ? 16'd1000 : 16'd3000;
        return AMOUNT_W'($urandom_range(65535));
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_request();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 15)
            return '1;
        else if (roll < 35)
            return AMOUNT_W'($urandom_range(255));
        else if (roll < 75)
            return AMOUNT_W'($urandom_range(4095));
        return AMOUNT_W'($urandom_range(65535));
    endfunction

    task automatic run_directed();
        send_item(OP_ALLOC, 4'd0, 16'd0);
        send_item(OP_ALLOC, 4'd0, 16'd1);
        send_item(OP_LOAD, 4'd0, 16'd100);
        send_item(OP_LOAD, 4'd2, 16'd300);
        send_item(OP_LOAD, 4'd3, 16'hFFFF);
        send_item(OP_LOAD, 4'd5, 16'd300);
        send_item(OP_LOAD, 4'd15, 16'd200);
        send_item(OP_ALLOC, 4'd0, 16'd150);
        send_item(OP_UNUSED, 4'd7, 16'hFFFF);
        send_item(OP_ALLOC, 4'd9, 16'hFFFF);
        send_item(OP_COMPACT, 4'd0, 16'd0);
        write_register(CFG_FIT_MODE, MODE_BEST);
        send_item(OP_ALLOC, 4'd0, 16'd100);
        send_item(OP_ALLOC, 4'd0, 16'd150);
        write_register(CFG_FIT_MODE, MODE_WORST);
        send_item(OP_LOAD, 4'd4, 16'd300);
        send_item(OP_ALLOC, 4'd0, 16'd10);
        write_register(CFG_FIT_MODE, MODE_UNUSED);
        send_item(OP_ALLOC, 4'd0, 16'd1);
        write_register(CFG_BLOCKS_IN_USE, 5'd0);
        send_item(OP_ALLOC, 4'd0, 16'd0);
        send_item(OP_COMPACT, 4'd0, 16'd0);
        write_register(CFG_BLOCKS_IN_USE, 5'd31);
        send_item(OP_LOAD, 4'd15, 16'hFFFF);
        send_item(OP_ALLOC, 4'd0, 16'hFFFF);
        write_register(CFG_BLOCKS_IN_USE, 5'd1);
        write_register(CFG_FIT_MODE, MODE_BEST);
        send_item(OP_LOAD, 4'd1, 16'd5000);
        send_item(OP_ALLOC, 4'd0, 16'd200);
        send_item(OP_COMPACT, 4'd0, 16'd0);
    endtask

    task automatic pick_settings();
        int roll;
        write_register(CFG_FIT_MODE, CFG_DATA_W'($urandom_range(31)));
        roll = $urandom_range(99);
        if (roll < 45)
            write_register(CFG_BLOCKS_IN_USE, 5'd16);
        else if (roll < 55)
            write_register(CFG_BLOCKS_IN_USE, 5'd31);
        else if (roll < 60)
            write_register(CFG_BLOCKS_IN_USE, 5'd0);
        else if (roll < 65)
            write_register(CFG_BLOCKS_IN_USE, 5'd1);
        else
            write_register(CFG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(2, 31)));
    endtask

    task automatic run_random();
        int sent;
        int burst;
        int k;
        int roll;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 62;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_settings();
            n     = sb.live_entries();
            burst = $urandom_range(15, 40);
            for (k = 0; k < burst; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 35)
                    send_item(OP_LOAD,
                              (n > 0 && $urandom_range(9) < 7)
                                  ? IDX_PORT_W'($urandom_range(n - 1))
                                  : IDX_PORT_W'($urandom_range(15)),
                              pick_load_size());
                else if (roll < 88)
                    send_item(OP_ALLOC, IDX_PORT_W'($urandom_range(15)), pick_request());
                else if (roll < 96)
                    send_item(OP_COMPACT, IDX_PORT_W'($urandom_range(15)),
                              AMOUNT_W'($urandom_range(65535)));
                else
                    send_item(OP_UNUSED, IDX_PORT_W'($urandom_range(15)),
                              AMOUNT_W'($urandom_range(65535)));
            end
            sent += burst;
        end
    endtask

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("partition_fit_allocator_top test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d loads, %0d allocations (%0d with no fit), %0d compactions",
                 sb.loads, sb.allocs, sb.no_fits, sb.compactions);
        $display("plus %0d unused-op items across %0d register writes, %0d mismatches",
                 sb.others, sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.expected_replies.size() == 0)
            $display("partition_fit_allocator_top test passed");
        else
            $display("partition_fit_allocator_top test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_fit_unit.sv
hw/rtl/partition_fit_allocator_top.sv
sim/tb_top.sv
